### design/dd96_pkg.sv
// Shared constants and types for the 96-bit scaled decimal divider.
package dd96_pkg;

    localparam int MANT_W = 96;
    localparam int SCALE_W = 5;
    localparam int MAX_SCALE_DEF = 28;
    // Covers a 96-bit mantissa times 10^28, times 10 once more, plus headroom.
    localparam int WIDE_W = 196;
    localparam int DIGIT_W = 4;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVF_POS  = 3'd1,
        ST_OVF_NEG  = 3'd2,
        ST_DIV_ZERO = 3'd3,
        ST_INVALID  = 3'd4
    } status_t;

    typedef struct packed {
        logic                 done;
        logic                 ovf;
        logic [SCALE_W-1:0]   scale;
    } dd96_res_t;

endpackage

### design/dd96_core.sv
// Alignment, restoring division and digit-by-digit refinement of the quotient.
module dd96_core #(
    parameter int MAX_SCALE = dd96_pkg::MAX_SCALE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          ack,
    input  logic [dd96_pkg::MANT_W-1:0]   a_mant,
    input  logic [dd96_pkg::SCALE_W-1:0]  a_scale,
    input  logic [dd96_pkg::MANT_W-1:0]   b_mant,
    input  logic [dd96_pkg::SCALE_W-1:0]  b_scale,
    output logic [dd96_pkg::MANT_W-1:0]   q_mant,
    output dd96_pkg::dd96_res_t           res
);
    localparam int W = dd96_pkg::WIDE_W;
    localparam int MW = dd96_pkg::MANT_W;
    localparam int DW = dd96_pkg::DIGIT_W;
    localparam int SW = dd96_pkg::SCALE_W;
    localparam int CW = $clog2(W + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_ALIGN, S_DIV, S_CHK, S_MUL, S_DIG, S_ADD, S_FIN
    } state_t;

    state_t                         state_reg;
    logic [W-1:0]                   num_reg, den_reg, rem_reg, bs_reg, q10_reg;
    logic [DW-1:0]                  dig_reg;
    logic [CW-1:0]                  cnt_reg;
    logic [dd96_pkg::SCALE_W-1:0]   asc_reg, bsc_reg, shift_reg;
    logic                           anz_reg;

    logic [W-1:0] div_try, div_diff, dig_diff, cand;
    logic         div_ge, dig_ge;

    function automatic logic [W-1:0] mul10(input logic [W-1:0] x);
        mul10 = (x << 3) + (x << 1);
    endfunction

    always_comb begin
        div_try  = {rem_reg[W-2:0], num_reg[W-1]};
        div_ge   = div_try >= den_reg;
        div_diff = div_try - den_reg;
        dig_ge   = rem_reg >= bs_reg;
        dig_diff = rem_reg - bs_reg;
        cand     = q10_reg + W'(dig_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        num_reg   <= W'(a_mant);
                        den_reg   <= W'(b_mant);
                        asc_reg   <= a_scale;
                        bsc_reg   <= b_scale;
                        anz_reg   <= |a_mant;
                        rem_reg   <= '0;
                        shift_reg <= '0;
                        state_reg <= S_ALIGN;
                    end
                end
                S_ALIGN: begin
                    // One power of ten per cycle on the operand with the smaller scale.
                    if (asc_reg < bsc_reg) begin
                        num_reg <= mul10(num_reg);
                        asc_reg <= asc_reg + 1'b1;
                    end else if (bsc_reg < asc_reg) begin
                        den_reg <= mul10(den_reg);
                        bsc_reg <= bsc_reg + 1'b1;
                    end else begin
                        cnt_reg   <= CW'(W);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    rem_reg <= div_ge ? div_diff : div_try;
                    num_reg <= {num_reg[W-2:0], div_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    if ((|rem_reg) && (shift_reg < SW'(MAX_SCALE))
                            && !(|num_reg[W-1:MW])) begin
                        state_reg <= S_MUL;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_MUL: begin
                    rem_reg   <= mul10(rem_reg);
                    q10_reg   <= mul10(num_reg);
                    bs_reg    <= den_reg << 3;
                    dig_reg   <= '0;
                    cnt_reg   <= CW'(DW);
                    state_reg <= S_DIG;
                end
                S_DIG: begin
                    // The next digit is below ten, so four restoring steps find it.
                    rem_reg <= dig_ge ? dig_diff : rem_reg;
                    dig_reg <= {dig_reg[DW-2:0], dig_ge};
                    bs_reg  <= bs_reg >> 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (|cand[W-1:MW]) begin
                        state_reg <= S_FIN;
                    end else begin
                        num_reg   <= cand;
                        shift_reg <= shift_reg + 1'b1;
                        state_reg <= S_CHK;
                    end
                end
                S_FIN: begin
                    if (ack) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign q_mant    = num_reg[MW-1:0];
    assign res.done  = state_reg == S_FIN;
    assign res.ovf   = (|num_reg[W-1:MW]) || (anz_reg && !(|num_reg));
    assign res.scale = shift_reg;

    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN) |-> (shift_reg <= SW'(MAX_SCALE)))
        else $error("quotient scale beyond limit");
    a_dig_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |=> (state_reg == S_DIG) ##4 (state_reg == S_ADD))
        else $error("digit step length wrong");
    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHK) |-> (rem_reg < den_reg))
        else $error("remainder not below divisor");
endmodule

### design/decimal_divide_96bit.sv
// Top level of the 96-bit scaled decimal divider: checks, handshake and output register.
//
//  channel  | direction | ports
//  ---------+-----------+-----------------------------------------------
//  s_       | in        | s_valid, s_ready, dividend and divisor fields
//  m_       | out       | m_valid, m_ready, quotient fields, m_status
//
// An item runs the alignment, one step per scale of difference, then the 196-step
// restoring divide and one refinement per fraction digit; the divide takes most time.
// Invalid scales and a zero divisor skip the core and go from T_IDLE straight to T_RES.
// One item is worked at a time; a new one is taken while a result waits at the output.
// aresetn is synchronous and active low and clears the control state only.
module decimal_divide_96bit #(
    parameter int MAX_SCALE = dd96_pkg::MAX_SCALE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [63:0]                   s_a_mant_lo,
    input  logic [31:0]                   s_a_mant_hi,
    input  logic [4:0]                    s_a_scale,
    input  logic                          s_a_neg,
    input  logic [63:0]                   s_b_mant_lo,
    input  logic [31:0]                   s_b_mant_hi,
    input  logic [4:0]                    s_b_scale,
    input  logic                          s_b_neg,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [63:0]                   m_q_mant_lo,
    output logic [31:0]                   m_q_mant_hi,
    output logic [4:0]                    m_q_scale,
    output logic                          m_q_neg,
    output logic [2:0]                    m_status
);
    typedef enum logic [1:0] {T_IDLE, T_RUN, T_RES} top_state_t;

    top_state_t                  state_reg;
    dd96_pkg::status_t           err_reg, err_next;
    logic                        neg_reg;
    logic                        m_valid_reg;
    logic [63:0]                 m_lo_reg;
    logic [31:0]                 m_hi_reg;
    logic [4:0]                  m_scale_reg;
    logic                        m_neg_reg;
    dd96_pkg::status_t           m_status_reg;

    logic                        accept, out_free, core_start;
    logic [dd96_pkg::MANT_W-1:0] q_mant;
    dd96_pkg::dd96_res_t         core_res;

    assign s_ready  = state_reg == T_IDLE;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        if (s_a_scale > 5'(MAX_SCALE) || s_b_scale > 5'(MAX_SCALE)) begin
            err_next = dd96_pkg::ST_INVALID;
        end else if (!(|{s_b_mant_hi, s_b_mant_lo})) begin
            err_next = dd96_pkg::ST_DIV_ZERO;
        end else begin
            err_next = dd96_pkg::ST_OK;
        end
    end

    assign core_start = accept && (err_next == dd96_pkg::ST_OK);

    dd96_core #(.MAX_SCALE(MAX_SCALE)) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (core_start),
        .ack     (state_reg == T_RES && out_free),
        .a_mant  ({s_a_mant_hi, s_a_mant_lo}),
        .a_scale (s_a_scale),
        .b_mant  ({s_b_mant_hi, s_b_mant_lo}),
        .b_scale (s_b_scale),
        .q_mant  (q_mant),
        .res     (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == T_RES && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        err_reg   <= err_next;
                        neg_reg   <= s_a_neg ^ s_b_neg;
                        state_reg <= (err_next == dd96_pkg::ST_OK) ? T_RUN : T_RES;
                    end
                end
                T_RUN: begin
                    if (core_res.done) begin
                        state_reg <= T_RES;
                    end
                end
                T_RES: begin
                    if (out_free) begin
                        if (err_reg != dd96_pkg::ST_OK) begin
                            m_lo_reg     <= '0;
                            m_hi_reg     <= '0;
                            m_scale_reg  <= '0;
                            m_neg_reg    <= 1'b0;
                            m_status_reg <= err_reg;
                        end else if (core_res.ovf) begin
                            m_lo_reg     <= '0;
                            m_hi_reg     <= '0;
                            m_scale_reg  <= '0;
                            m_neg_reg    <= neg_reg;
                            m_status_reg <= neg_reg ? dd96_pkg::ST_OVF_NEG
                                                    : dd96_pkg::ST_OVF_POS;
                        end else begin
                            m_lo_reg     <= q_mant[63:0];
                            m_hi_reg     <= q_mant[95:64];
                            m_scale_reg  <= core_res.scale;
                            m_neg_reg    <= neg_reg;
                            m_status_reg <= dd96_pkg::ST_OK;
                        end
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_q_mant_lo = m_lo_reg;
    assign m_q_mant_hi = m_hi_reg;
    assign m_q_scale   = m_scale_reg;
    assign m_q_neg     = m_neg_reg;
    assign m_status    = m_status_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != dd96_pkg::ST_OK)
            |-> (m_q_mant_lo == '0 && m_q_mant_hi == '0 && m_q_scale == '0))
        else $error("error result carries a nonzero quotient");
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second transaction taken while busy");
    a_bad_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == dd96_pkg::ST_DIV_ZERO || m_status == dd96_pkg::ST_INVALID))
            |-> !m_q_neg)
        else $error("operand error with a sign set");
endmodule

### tb/tb_top.sv
// Testbench for the 96-bit scaled decimal divider with a queue-fed driver and a checking monitor.
`timescale 1ns / 100ps

module tb_top;

    localparam int WD_LIMIT = 12000;
    localparam int HOLD_CYCLES = 1500;
    localparam int DRAIN_CYCLES = 500;
    localparam int RAND_ITEMS = 800;

    typedef struct {
        logic [95:0] a_mant;
        logic [4:0]  a_scale;
        logic        a_neg;
        logic [95:0] b_mant;
        logic [4:0]  b_scale;
        logic        b_neg;
    } operands_t;

    typedef struct {
        logic [95:0]       q_mant;
        logic [4:0]        q_scale;
        logic              q_neg;
        dd96_pkg::status_t status;
    } quotient_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [63:0] s_a_mant_lo;
    logic [31:0] s_a_mant_hi;
    logic [4:0] s_a_scale;
    logic s_a_neg;
    logic [63:0] s_b_mant_lo;
    logic [31:0] s_b_mant_hi;
    logic [4:0] s_b_scale;
    logic s_b_neg;
    logic m_valid;
    logic m_ready;
    logic [63:0] m_q_mant_lo;
    logic [31:0] m_q_mant_hi;
    logic [4:0] m_q_scale;
    logic m_q_neg;
    logic [2:0] m_status;

    operands_t pending_ops[$];
    quotient_t expected_quotients[$];
    int errors = 0;
    int accepted_in = 0;
    bit quiet = 0;
    int idle_cnt = 0;
    int stall_cnt = 0;
    int hold_cnt = 0;
    bit hold_done = 0;
    int wd_cnt = 0;

    decimal_divide_96bit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_mant_lo(s_a_mant_lo), .s_a_mant_hi(s_a_mant_hi),
        .s_a_scale(s_a_scale), .s_a_neg(s_a_neg),
        .s_b_mant_lo(s_b_mant_lo), .s_b_mant_hi(s_b_mant_hi),
        .s_b_scale(s_b_scale), .s_b_neg(s_b_neg),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_q_mant_lo(m_q_mant_lo), .m_q_mant_hi(m_q_mant_hi),
        .m_q_scale(m_q_scale), .m_q_neg(m_q_neg), .m_status(m_status)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Checks the operands, aligns the scales, divides, appends truncated fraction digits and flags overflow.
    function automatic quotient_t divide_decimal(operands_t op);
        quotient_t res;
        logic [255:0] num, den, quo, rem, cand;
        int digits;
        res.q_mant = '0;
        res.q_scale = '0;
        res.q_neg = 1'b0;
        res.status = dd96_pkg::ST_OK;
        if (op.a_scale > dd96_pkg::MAX_SCALE_DEF || op.b_scale > dd96_pkg::MAX_SCALE_DEF) begin
            res.status = dd96_pkg::ST_INVALID;
            return res;
        end
        if (op.b_mant == '0) begin
            res.status = dd96_pkg::ST_DIV_ZERO;
            return res;
        end
        num = {160'd0, op.a_mant};
        den = {160'd0, op.b_mant};
        for (int i = op.a_scale; i < op.b_scale; i++) num = num * 10;
        for (int i = op.b_scale; i < op.a_scale; i++) den = den * 10;
        quo = num / den;
        rem = num % den;
        digits = 0;
        while (rem != '0 && digits < dd96_pkg::MAX_SCALE_DEF && quo[255:96] == '0) begin
            rem = rem * 10;
            cand = quo * 10 + rem / den;
            rem = rem % den;
            if (cand[255:96] != '0) break;
            quo = cand;
            digits++;
        end
        res.q_neg = op.a_neg ^ op.b_neg;
        if (quo[255:96] != '0 || (op.a_mant != '0 && quo == '0)) begin
            res.status = res.q_neg ? dd96_pkg::ST_OVF_NEG : dd96_pkg::ST_OVF_POS;
            return res;
        end
        res.q_mant = quo[95:0];
        res.q_scale = digits[4:0];
        return res;
    endfunction

    function automatic logic [95:0] rand_mant();
        logic [95:0] m;
        int len;
        m = {$urandom, $urandom, $urandom};
        len = $urandom_range(0, 96);
        if (len < 96) m = m & ((96'd1 << len) - 1);
        return m;
    endfunction

    function automatic operands_t rand_operands();
        operands_t op;
        op.a_mant = rand_mant();
        op.b_mant = rand_mant();
        if ($urandom_range(0, 19) == 0) op.b_mant = '0;
        op.a_scale = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(0, 28));
        op.b_scale = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(0, 28));
        op.a_neg = 1'($urandom_range(0, 1));
        op.b_neg = 1'($urandom_range(0, 1));
        return op;
    endfunction

    function automatic operands_t mk(logic [95:0] am, int asc, logic an,
                                     logic [95:0] bm, int bsc, logic bn);
        operands_t op;
        op.a_mant = am;
        op.a_scale = asc[4:0];
        op.a_neg = an;
        op.b_mant = bm;
        op.b_scale = bsc[4:0];
        op.b_neg = bn;
        return op;
    endfunction

    // Driver: a new transaction is presented only once the previous one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_quotients.push_back(divide_decimal('{
                    {s_a_mant_hi, s_a_mant_lo}, s_a_scale, s_a_neg,
                    {s_b_mant_hi, s_b_mant_lo}, s_b_scale, s_b_neg}));
                accepted_in++;
            end
            if (!s_valid || s_ready) begin
                if (idle_cnt > 0) begin
                    idle_cnt <= idle_cnt - 1;
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    idle_cnt <= $urandom_range(0, 12);
                    s_valid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    operands_t op;
                    op = pending_ops.pop_front();
                    {s_a_mant_hi, s_a_mant_lo} <= op.a_mant;
                    s_a_scale <= op.a_scale;
                    s_a_neg <= op.a_neg;
                    {s_b_mant_hi, s_b_mant_lo} <= op.b_mant;
                    s_b_scale <= op.b_scale;
                    s_b_neg <= op.b_neg;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result and paces m_ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_quotients.size() == 0) begin
                    $error("result with no transaction outstanding");
                    errors++;
                end else begin
                    quotient_t exp_q;
                    exp_q = expected_quotients.pop_front();
                    if (m_q_mant_lo !== exp_q.q_mant[63:0]) begin
                        $error("q_mant_lo expected %0h actual %0h", exp_q.q_mant[63:0],
                               m_q_mant_lo);
                        errors++;
                    end
                    if (m_q_mant_hi !== exp_q.q_mant[95:64]) begin
                        $error("q_mant_hi expected %0h actual %0h", exp_q.q_mant[95:64],
                               m_q_mant_hi);
                        errors++;
                    end
                    if (m_q_scale !== exp_q.q_scale) begin
                        $error("q_scale expected %0d actual %0d", exp_q.q_scale, m_q_scale);
                        errors++;
                    end
                    if (m_q_neg !== exp_q.q_neg) begin
                        $error("q_neg expected %0d actual %0d", exp_q.q_neg, m_q_neg);
                        errors++;
                    end
                    if (m_status !== exp_q.status) begin
                        $error("status expected %0d actual %0d", exp_q.status, m_status);
                        errors++;
                    end
                end
            end
            // One long hold-off lets the block fill up and push back on the input.
            if (!hold_done && accepted_in == 200) begin
                hold_done <= 1'b1;
                hold_cnt <= HOLD_CYCLES;
                m_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready <= (hold_cnt == 1);
            end else if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                m_ready <= (stall_cnt == 1);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_cnt <= $urandom_range(1, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            wd_cnt <= 0;
        end else begin
            wd_cnt <= wd_cnt + 1;
        end
        if (wd_cnt >= WD_LIMIT) begin
            $display("decimal_divide_96bit verification failed");
            $finish;
        end
    end

    initial begin
        logic [95:0] ones;
        ones = '1;
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        {s_a_mant_hi, s_a_mant_lo} = '0;
        {s_b_mant_hi, s_b_mant_lo} = '0;
        s_a_scale = '0;
        s_b_scale = '0;
        s_a_neg = 1'b0;
        s_b_neg = 1'b0;

        pending_ops.push_back(mk(96'd1, 0, 0, 96'd3, 0, 0));
        pending_ops.push_back(mk(96'd10, 1, 1, 96'd4, 0, 0));
        pending_ops.push_back(mk(ones, 0, 0, 96'd1, 0, 1));
        pending_ops.push_back(mk(ones, 0, 1, ones, 0, 1));
        pending_ops.push_back(mk(ones, 28, 0, ones, 0, 0));
        pending_ops.push_back(mk(ones, 0, 0, 96'd1, 28, 0));
        pending_ops.push_back(mk(ones, 0, 1, 96'd1, 28, 0));
        pending_ops.push_back(mk(96'd1, 28, 0, ones, 0, 0));
        pending_ops.push_back(mk(96'd1, 28, 1, ones, 0, 0));
        pending_ops.push_back(mk(96'd0, 5, 1, 96'd7, 2, 0));
        pending_ops.push_back(mk(96'd0, 0, 0, 96'd7, 0, 0));
        pending_ops.push_back(mk(96'd5, 3, 0, 96'd0, 3, 0));
        pending_ops.push_back(mk(96'd5, 3, 1, 96'd0, 31, 1));
        pending_ops.push_back(mk(96'd5, 29, 0, 96'd3, 0, 0));
        pending_ops.push_back(mk(96'd5, 0, 1, 96'd3, 31, 1));
        pending_ops.push_back(mk(ones, 31, 1, 96'd0, 28, 0));
        pending_ops.push_back(mk(96'd2, 28, 0, 96'd3, 28, 0));
        pending_ops.push_back(mk(96'd22, 0, 0, 96'd7, 0, 1));
        pending_ops.push_back(mk(ones, 14, 0, 96'd7, 0, 0));
        for (int i = 0; i < RAND_ITEMS; i++) pending_ops.push_back(rand_operands());

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_ops.size() < 60);
        quiet = 1;
        wait (pending_ops.size() == 0 && !s_valid && expected_quotients.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_quotients.size() != 0) begin
            $error("%0d results never arrived", expected_quotients.size());
            errors++;
        end
        if (errors == 0) begin
            $display("decimal_divide_96bit verification clean");
        end else begin
            $display("decimal_divide_96bit verification failed");
        end
        $finish;
    end

endmodule

### files.f
design/dd96_pkg.sv
design/dd96_core.sv
design/decimal_divide_96bit.sv
tb/tb_top.sv
